[sv/eidt_pkg.sv]
// ============================================================================
// eidt_pkg
// Shared types and constants for the expiring identifier duplicate filter:
// table geometry, field widths, the stored entry layout and the scan result.
// ============================================================================
package eidt_pkg;

	// Table geometry.
	localparam int ENTRIES = 1024;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int FILL_W  = $clog2(ENTRIES + 1);

	// Field widths.
	localparam int ID_W   = 64;
	localparam int TIME_W = 48;
	localparam int LIFE_W = 20;

	// Lifetime register value after reset, in milliseconds.
	localparam logic [LIFE_W-1:0] LIFETIME_RESET = LIFE_W'(30000);

	// Largest representable time; expiry saturates here.
	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	// One stored table entry.
	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic [TIME_W-1:0] expiry;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Outcome of one table scan, valid in the cycle that done is high.
	typedef struct packed {
		logic             done;
		logic             seen;
		logic [IDX_W-1:0] victim;
	} scan_res_t;

endpackage

[sv/expiring_id_dedup_table_core.sv]
// ============================================================================
// expiring_id_dedup_table_core
// Duplicate filter for 64-bit identifiers with a per-entry expiry time,
// held in a 1024-entry table RAM.
// ============================================================================
// Usage:
// Input beats (in_valid/in_ready) carry item_id and now_ms. Each input
// beat yields exactly one output beat (out_valid/out_ready) with seen = 1
// for a live duplicate, or seen = 0 when the identifier has been recorded.
// The configuration channel (cfg_valid/cfg_ready) writes lifetime_ms; it is
// always ready and should only be written while no item is in flight.
// Scan: an item examines 1 to 1024 table entries (stopping at a live match
// or at the first expired entry), one entry per cycle through the single
// RAM read port, before its result is loaded into the output register.
// The next item is accepted in the cycle after the result is loaded, so
// items are not overlapped.
// Reset clears the lifetime to 30000 ms and the fill count to zero; table
// entries at or above the fill count read as expired, so no clearing pass
// runs.
// A result that the receiver stalls stays in the output register; the
// next item is scanned meanwhile and waits for that register to free up.
// ============================================================================
module expiring_id_dedup_table_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [eidt_pkg::ID_W-1:0]     item_id,
	input  logic [eidt_pkg::TIME_W-1:0]   now_ms,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          seen,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [eidt_pkg::LIFE_W-1:0]   lifetime_ms
);

	import eidt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SCAN   = 3'b010,
		S_FINISH = 3'b100
	} state_t;

	state_t            state_q;
	logic [LIFE_W-1:0] lifetime_q;
	logic [FILL_W-1:0] fill_q;
	logic [ID_W-1:0]   id_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] exp_q;
	logic              seen_q;
	logic [IDX_W-1:0]  victim_q;
	logic              out_valid_q;
	logic              out_seen_q;

	logic              in_fire;
	logic              out_free;
	logic              finish;
	logic [TIME_W:0]   exp_sum;
	logic              ram_we;
	entry_t            ram_wdata;
	logic              ram_re;
	logic [IDX_W-1:0]  ram_raddr;
	entry_t            ram_rdata;
	scan_res_t         scan_res;

	assign in_ready  = state_q == S_IDLE;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign seen      = out_seen_q;
	assign out_free  = !out_valid_q || out_ready;
	assign finish    = (state_q == S_FINISH) && out_free;

	// Expiry of a new record: now plus lifetime, saturated at the top of time.
	assign exp_sum = {1'b0, now_ms} + (TIME_W + 1)'(lifetime_q);

	// Lifetime register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lifetime_q <= LIFETIME_RESET;
		end else if (cfg_valid && cfg_ready) begin
			lifetime_q <= lifetime_ms;
		end
	end

	// Item capture on input accept.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			id_q  <= item_id;
			now_q <= now_ms;
			exp_q <= exp_sum[TIME_W] ? TIME_MAX : exp_sum[TIME_W-1:0];
		end
	end

	// Scan outcome capture.
	always_ff @(posedge clk) begin
		if (scan_res.done) begin
			seen_q   <= scan_res.seen;
			victim_q <= scan_res.victim;
		end
	end

	// Item sequencing. The table is written only once the scan has stopped,
	// so a read never overlaps a write to the same entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_res.done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Fill count: entries below it have been written at least once. Writes
	// only ever land on the first never-written entry or below it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (ram_we && (FILL_W'(victim_q) == fill_q)) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_seen_q <= seen_q;
		end
	end

	// Table write on a miss.
	assign ram_we           = finish && !seen_q;
	assign ram_wdata.id     = id_q;
	assign ram_wdata.expiry = exp_q;

	eidt_ram #(
		.DEPTH (ENTRIES),
		.WIDTH (ENTRY_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (victim_q),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	eidt_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (in_fire),
		.id      (id_q),
		.now     (now_q),
		.fill    (fill_q),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata),
		.res     (scan_res)
	);

`ifndef ASSERT_OFF
	// The table is written only after a scan ends in a miss.
	a_write_after_miss: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_FINISH) && !seen_q)
		else $error("table written outside a finished miss");

	// A scan reports completion only while the sequencer waits for it.
	a_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_res.done |-> (state_q == S_SCAN))
		else $error("scan completion outside the scan state");

	// The fill count grows by one at most and never passes the table size.
	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q != $past(fill_q)) |-> (fill_q == $past(fill_q) + 1'b1))
		else $error("fill count changed by more than one");

	a_fill_max: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(ENTRIES))
		else $error("fill count above table size");
`endif

endmodule

[sv/eidt_ram.sv]
// ============================================================================
// eidt_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read data output. No reset.
// ============================================================================
module eidt_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 112
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port with registered output.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[sv/eidt_scan.sv]
// ============================================================================
// eidt_scan
// Table scan sequencer. Issues one read per cycle in index order and checks
// each returned entry for a live match, an expired slot, or a better
// replacement candidate (earliest expiry, lowest index on ties).
// ============================================================================
module eidt_scan (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [eidt_pkg::ID_W-1:0]     id,
	input  logic [eidt_pkg::TIME_W-1:0]   now,
	input  logic [eidt_pkg::FILL_W-1:0]   fill,
	output logic                          rd_en,
	output logic [eidt_pkg::IDX_W-1:0]    rd_addr,
	input  eidt_pkg::entry_t              rd_data,
	output eidt_pkg::scan_res_t           res
);

	import eidt_pkg::*;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	logic              issue_q;
	logic [IDX_W-1:0]  rd_addr_q;
	logic              v_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic              have_best_q;
	logic [TIME_W-1:0] best_exp_q;
	logic [IDX_W-1:0]  best_idx_q;

	entry_t            ent;
	logic              live;
	logic              match;
	logic              last;
	logic              take_best;
	logic [IDX_W-1:0]  best_idx_next;

	assign rd_en   = issue_q;
	assign rd_addr = rd_addr_q;

	// Evaluate the entry returned by the RAM. Entries at or above the fill
	// count were never written and read as all zeros (expired).
	always_comb begin
		ent           = (FILL_W'(idx_s1) < fill) ? rd_data : '0;
		live          = ent.expiry > now;
		match         = live && (ent.id == id);
		last          = idx_s1 == LAST_IDX;
		take_best     = !have_best_q || (ent.expiry < best_exp_q);
		best_idx_next = take_best ? idx_s1 : best_idx_q;
		res.done      = v_s1 && (match || !live || last);
		res.seen      = match;
		res.victim    = live ? best_idx_next : idx_s1;
	end

	// Read issue control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q   <= 1'b0;
			rd_addr_q <= '0;
			v_s1      <= 1'b0;
		end else if (start) begin
			issue_q   <= 1'b1;
			rd_addr_q <= '0;
			v_s1      <= 1'b0;
		end else begin
			v_s1 <= issue_q && !res.done;
			if (issue_q) begin
				rd_addr_q <= rd_addr_q + 1'b1;
				if (rd_addr_q == LAST_IDX) begin
					issue_q <= 1'b0;
				end
			end
			if (res.done) begin
				issue_q <= 1'b0;
			end
		end
	end

	// Index of the entry whose data arrives next cycle.
	always_ff @(posedge clk) begin
		idx_s1 <= rd_addr_q;
	end

	// Replacement candidate tracking over live, non-matching entries.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_best_q <= 1'b0;
		end else if (start) begin
			have_best_q <= 1'b0;
		end else if (v_s1 && !res.done) begin
			have_best_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && !res.done && take_best) begin
			best_exp_q <= ent.expiry;
			best_idx_q <= idx_s1;
		end
	end

endmodule
